[src/assert_macros.svh]
// Assertion macros shared by the RTL in this folder.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled during reset.
`define CHECK_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mwpm assertion failed");

// Clocked invariant check.
`define CHECK_ALWAYS(label, clk, rst_n, expr) \
    `CHECK_PROP(label, clk, rst_n, (expr))

`endif

[src/mwpm_pkg.sv]
// Types and constants for the mecanum wheel PWM mixer.
// No dependencies.
package mwpm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [15:0] vel_t;
    typedef logic [7:0]         duty_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WHEEL_RADIUS = 3'd0,
        REG_LEVER_SUM    = 3'd1,
        REG_GEAR_RATIO   = 3'd2,
        REG_MAX_RPM      = 3'd3,
        REG_MIN_DUTY     = 3'd4,
        REG_MAX_DUTY     = 3'd5,
        REG_DEAD_ZONE    = 3'd6
    } cfg_reg_t;

    // 60 / (2*pi) in Q.16
    localparam logic [19:0] RPM_PER_RAD_Q16 = 20'd625823;

    localparam logic [9:0]  RST_RADIUS    = 10'd40;
    localparam logic [11:0] RST_LEVER     = 12'd200;
    localparam logic [7:0]  RST_GEAR      = 8'd48;
    localparam logic [15:0] RST_MAX_RPM   = 16'd9600;
    localparam logic [7:0]  RST_MIN_DUTY  = 8'd0;
    localparam logic [7:0]  RST_MAX_DUTY  = 8'd255;
    localparam logic [9:0]  RST_DEAD_ZONE = 10'd1;

    localparam int NUM_WHEELS = 4;

endpackage

[src/mecanum_wheel_pwm_mixer.sv]
// Mecanum wheel PWM mixer top level: kinematics, rate divider, rpm scaling, duty divider.
// Depends on mwpm_pkg and assert_macros.svh.
//
// Takes one body velocity command per transaction and returns the four wheel duties and
// direction bits. A new transaction can enter every cycle while the pipeline advances;
// it is built around two bit-per-stage restoring dividers (RATE_FRAC_BITS + 18 stages for
// rim speed over radius, 8 stages for the duty mapping). The whole pipeline holds when a
// result waits at the output. Configuration writes take effect at once and belong to
// idle periods.
`include "assert_macros.svh"

module mecanum_wheel_pwm_mixer #(
    parameter int RATE_FRAC_BITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mwpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mwpm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mwpm_pkg::vel_t                    vel_x,
    input  mwpm_pkg::vel_t                    vel_y,
    input  mwpm_pkg::vel_t                    yaw_rate,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mwpm_pkg::duty_t                   duty_left_front,
    output mwpm_pkg::duty_t                   duty_right_front,
    output mwpm_pkg::duty_t                   duty_left_back,
    output mwpm_pkg::duty_t                   duty_right_back,
    output logic                              fwd_left_front,
    output logic                              fwd_right_front,
    output logic                              fwd_left_back,
    output logic                              fwd_right_back
);
    import mwpm_pkg::*;

    localparam int F      = RATE_FRAC_BITS;
    localparam int MAGW   = 28;
    localparam int RIMW   = 29;
    localparam int QW     = F + 18;
    localparam int RCW    = F + 14;
    localparam int PW     = F + 22;
    localparam int MW     = F + 34;
    localparam int DENW   = F + 32;
    localparam int NW     = F + 41;
    localparam int NMETA  = 12;
    localparam int NST    = QW + 15;
    localparam int VP_DIV = 1;
    localparam int VP_MET = QW + 2;

    localparam logic [RCW-1:0] RATE_LIM = RCW'(1) << (F + 13);

    // configuration
    logic [9:0]  radius_reg;
    logic [11:0] lever_reg;
    logic [7:0]  gear_reg;
    logic [15:0] rpm_reg;
    logic [7:0]  min_reg;
    logic [7:0]  max_reg;
    logic [9:0]  dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RST_RADIUS;
            lever_reg  <= RST_LEVER;
            gear_reg   <= RST_GEAR;
            rpm_reg    <= RST_MAX_RPM;
            min_reg    <= RST_MIN_DUTY;
            max_reg    <= RST_MAX_DUTY;
            dz_reg     <= RST_DEAD_ZONE;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WHEEL_RADIUS: radius_reg <= cfg_data[9:0];
                REG_LEVER_SUM:    lever_reg  <= cfg_data[11:0];
                REG_GEAR_RATIO:   gear_reg   <= cfg_data[7:0];
                REG_MAX_RPM:      rpm_reg    <= cfg_data[15:0];
                REG_MIN_DUTY:     min_reg    <= cfg_data[7:0];
                REG_MAX_DUTY:     max_reg    <= cfg_data[7:0];
                REG_DEAD_ZONE:    dz_reg     <= cfg_data[9:0];
                default:          ;
            endcase
        end
    end

    logic [9:0]        radius_eff;
    logic [15:0]       rpm_eff;
    logic [DENW-1:0]   den;
    logic [DENW:0]     dvs;
    logic signed [8:0] span;
    logic              dneg;
    logic [7:0]        span_mag;

    assign radius_eff = (radius_reg == '0) ? 10'd1 : radius_reg;
    assign rpm_eff    = (rpm_reg == '0) ? 16'd1 : rpm_reg;
    assign den        = {rpm_eff, {(F + 16){1'b0}}};
    assign dvs        = {den, 1'b0};
    assign span       = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});
    assign dneg       = span[8];
    assign span_mag   = dneg ? 8'(-span) : span[7:0];

    // pipeline control
    logic [NST-1:0] valid_reg;
    logic           adv;

    assign adv       = !valid_reg[NST-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = valid_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NST-2:0], in_valid};
    end

    // stage 1: sums and turn term
    logic signed [16:0] diff_reg;
    logic signed [16:0] sum_reg;
    logic signed [28:0] turn_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg <= 17'(vel_x) - 17'(vel_y);
            sum_reg  <= 17'(vel_x) + 17'(vel_y);
            turn_reg <= 29'($signed({1'b0, lever_reg})) * 29'(yaw_rate);
        end
    end

    // stage 2: rim speeds, then rate divider
    logic [QW-1:0] qd_reg  [QW+1][NUM_WHEELS];
    logic [9:0]    rem_reg [QW+1][NUM_WHEELS];
    logic          neg_reg [QW+1][NUM_WHEELS];

    logic signed [RIMW-1:0] rim      [NUM_WHEELS];
    logic [MAGW-1:0]        rim_mag  [NUM_WHEELS];
    logic [QW-1:0]          rim_t    [NUM_WHEELS];

    always_comb
    begin
        logic signed [RIMW-1:0] dq;
        logic signed [RIMW-1:0] sq;
        logic signed [RIMW-1:0] neg_v;
        logic [MAGW+F-1:0]      sh;
        dq = RIMW'(diff_reg) <<< 10;
        sq = RIMW'(sum_reg) <<< 10;
        rim[0] = dq - turn_reg;
        rim[1] = sq + turn_reg;
        rim[2] = sq - turn_reg;
        rim[3] = dq + turn_reg;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            neg_v      = -rim[w];
            rim_mag[w] = rim[w][RIMW-1] ? neg_v[MAGW-1:0] : rim[w][MAGW-1:0];
            sh         = {rim_mag[w], {F{1'b0}}};
            rim_t[w]   = sh[MAGW+F-1:10];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                qd_reg[0][w]  <= rim_t[w];
                rem_reg[0][w] <= '0;
                neg_reg[0][w] <= rim[w][RIMW-1];
            end
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_rate_div
        logic [QW-1:0] qd_next  [NUM_WHEELS];
        logic [9:0]    rem_next [NUM_WHEELS];

        always_comb
        begin
            logic [10:0] r;
            logic        ge;
            logic [10:0] r2;
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                r           = {rem_reg[k-1][w], qd_reg[k-1][w][QW-1]};
                ge          = r >= {1'b0, radius_eff};
                r2          = ge ? r - {1'b0, radius_eff} : r;
                rem_next[w] = r2[9:0];
                qd_next[w]  = {qd_reg[k-1][w][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int w = 0; w < NUM_WHEELS; w++)
                begin
                    qd_reg[k][w]  <= qd_next[w];
                    rem_reg[k][w] <= rem_next[w];
                    neg_reg[k][w] <= neg_reg[k-1][w];
                end
            end
        end
    end

    // rpm scaling and duty numerator
    logic            dead_reg [NMETA][NUM_WHEELS];
    logic            fwd_reg  [NMETA][NUM_WHEELS];
    logic [PW-1:0]   p_reg    [NUM_WHEELS];
    logic [MW-1:0]   m_reg    [NUM_WHEELS];
    logic [DENW-1:0] ms_reg   [NUM_WHEELS];

    logic            dead3 [NUM_WHEELS];
    logic            fwd3  [NUM_WHEELS];
    logic [PW-1:0]   p3    [NUM_WHEELS];
    logic [MW-1:0]   m4    [NUM_WHEELS];
    logic [DENW-1:0] ms5   [NUM_WHEELS];
    logic [NW-1:0]   n6    [NUM_WHEELS];

    always_comb
    begin
        logic [QW-1:0]  rate;
        logic [RCW-1:0] rate_c;
        logic [RCW-1:0] p_c;
        logic [NW-1:0]  a2;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            rate     = qd_reg[QW][w];
            dead3[w] = {rate, 10'b0} < (QW + 10)'({dz_reg, {F{1'b0}}});
            fwd3[w]  = !(neg_reg[QW][w] && (rate != '0));
            rate_c   = (rate >= QW'(RATE_LIM)) ? RATE_LIM : rate[RCW-1:0];
            p3[w]    = PW'(rate_c) * PW'(gear_reg);

            p_c      = (p_reg[w] > PW'(RATE_LIM)) ? RATE_LIM : p_reg[w][RCW-1:0];
            m4[w]    = MW'(p_c) * MW'(RPM_PER_RAD_Q16);

            ms5[w]   = (m_reg[w] > MW'(den)) ? den : m_reg[w][DENW-1:0];

            a2       = NW'(ms_reg[w]) * NW'(span_mag);
            n6[w]    = (a2 << 1) + NW'(den) - NW'(dneg);
        end
    end

    logic [NW-1:0] rem2_reg [9][NUM_WHEELS];
    logic [7:0]    q2_reg   [9][NUM_WHEELS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                dead_reg[0][w] <= dead3[w];
                fwd_reg[0][w]  <= fwd3[w];
                p_reg[w]       <= p3[w];
                m_reg[w]       <= m4[w];
                ms_reg[w]      <= ms5[w];
                rem2_reg[0][w] <= n6[w];
                q2_reg[0][w]   <= '0;
                for (int i = 1; i < NMETA; i++)
                begin
                    dead_reg[i][w] <= dead_reg[i-1][w];
                    fwd_reg[i][w]  <= fwd_reg[i-1][w];
                end
            end
        end
    end

    // duty divider: 8 quotient bits, MSB first
    for (genvar j = 1; j <= 8; j++)
    begin : g_duty_div
        logic [NW-1:0] rem_next [NUM_WHEELS];
        logic [7:0]    q_next   [NUM_WHEELS];

        always_comb
        begin
            logic [NW-1:0] d_sh;
            logic          ge;
            d_sh = NW'(dvs) << (8 - j);
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                ge          = rem2_reg[j-1][w] >= d_sh;
                rem_next[w] = ge ? rem2_reg[j-1][w] - d_sh : rem2_reg[j-1][w];
                q_next[w]   = {q2_reg[j-1][w][6:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int w = 0; w < NUM_WHEELS; w++)
                begin
                    rem2_reg[j][w] <= rem_next[w];
                    q2_reg[j][w]   <= q_next[w];
                end
            end
        end
    end

    // final: offset, clamp, dead zone
    duty_t duty_reg [NUM_WHEELS];
    logic  dir_reg  [NUM_WHEELS];
    duty_t duty_fin [NUM_WHEELS];

    always_comb
    begin
        logic signed [9:0] k_s;
        logic signed [9:0] val;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            k_s = $signed({2'b00, q2_reg[8][w]});
            val = $signed({2'b00, min_reg}) + (dneg ? -k_s : k_s);
            if (dead_reg[NMETA-1][w])
                duty_fin[w] = '0;
            else if (val < 0)
                duty_fin[w] = '0;
            else if (val > 10'sd255)
                duty_fin[w] = 8'd255;
            else
                duty_fin[w] = val[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                duty_reg[w] <= duty_fin[w];
                dir_reg[w]  <= fwd_reg[NMETA-1][w];
            end
        end
    end

    assign duty_left_front  = duty_reg[0];
    assign duty_right_front = duty_reg[1];
    assign duty_left_back   = duty_reg[2];
    assign duty_right_back  = duty_reg[3];
    assign fwd_left_front   = dir_reg[0];
    assign fwd_right_front  = dir_reg[1];
    assign fwd_left_back    = dir_reg[2];
    assign fwd_right_back   = dir_reg[3];

    `CHECK_ALWAYS(a_rate_rem, clk, rst_n, !valid_reg[VP_DIV + QW] || (rem_reg[QW][0] < radius_eff))
    `CHECK_ALWAYS(a_rpm_sat, clk, rst_n, !valid_reg[VP_MET + 2] || (ms_reg[1] <= den))
    `CHECK_ALWAYS(a_duty_rem, clk, rst_n, !valid_reg[VP_MET + NMETA - 1] || (rem2_reg[8][2] < NW'(dvs)))
    `CHECK_PROP(a_dead_zero, clk, rst_n, (adv && valid_reg[VP_MET + NMETA - 1] && dead_reg[NMETA-1][0]) |=> (duty_left_front == '0))

endmodule
